// ===== hdl/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg - page frame bitmap allocator package
// Widths, command and status codes, saturating counter helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

  localparam int unsigned FRAMES     = 65536;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int unsigned MW         = 32;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned WORDS      = FRAMES / MW;
  localparam int unsigned WADDR_W    = FRAME_W - BIT_W;
  localparam int unsigned SUM_W      = PFN_W + 1;

  localparam logic [1:0] CMD_ENABLE  = 2'd0;
  localparam logic [1:0] CMD_DISABLE = 2'd1;
  localparam logic [1:0] CMD_ALLOC   = 2'd2;
  localparam logic [1:0] CMD_FREE    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] byte_length;
    logic [CNT_W-1:0]  page_count;
  } pfba_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  free_pages;
  } pfba_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic clearing;
  } pfba_stat_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [PFN_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(FRAMES)) return CNT_W'(FRAMES);
    return s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                               input logic [PFN_W-1:0] b);
    if (SUM_W'(a) > SUM_W'(b)) return CNT_W'(SUM_W'(a) - SUM_W'(b));
    return '0;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pfba_if.sv =====
// ----------------------------------------------------------------------------
// pfba_if - allocator channel interfaces
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfba_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [pfba_pkg::ADDR_W-1:0]   address;
  logic [pfba_pkg::ADDR_W-1:0]   byte_length;
  logic [pfba_pkg::CNT_W-1:0]    page_count;
  modport source (output valid, command, address, byte_length, page_count, input ready);
  modport sink   (input valid, command, address, byte_length, page_count, output ready);
endinterface

interface pfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [pfba_pkg::ADDR_W-1:0]   page_address;
  logic [pfba_pkg::CNT_W-1:0]    free_pages;
  modport source (output valid, status, page_address, free_pages, input ready);
  modport sink   (input valid, status, page_address, free_pages, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfba_map_ram.sv =====
// ----------------------------------------------------------------------------
// pfba_map_ram - frame bitmap storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_map_ram (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [pfba_pkg::WADDR_W-1:0]   waddr_i,
  input  wire logic [pfba_pkg::MW-1:0]        wdata_i,
  input  wire logic                           re_i,
  input  wire logic [pfba_pkg::WADDR_W-1:0]   raddr_i,
  output logic      [pfba_pkg::MW-1:0]        rdata_o
);
  import pfba_pkg::*;

  logic [MW-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pfba_seq.sv =====
// ----------------------------------------------------------------------------
// pfba_seq - allocator sequencer
// Clearing pass, word read-modify-write over frame ranges, first-fit scan.
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_seq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire pfba_pkg::pfba_cmd_t            cmd_i,
  input  wire logic                           slot_free_i,
  output pfba_pkg::pfba_stat_t                stat_o,
  output pfba_pkg::pfba_rsp_t                 rsp_o,
  output logic                                we_o,
  output logic      [pfba_pkg::WADDR_W-1:0]   waddr_o,
  output logic      [pfba_pkg::MW-1:0]        wdata_o,
  output logic                                re_o,
  output logic      [pfba_pkg::WADDR_W-1:0]   raddr_o,
  input  wire logic [pfba_pkg::MW-1:0]        rdata_i
);
  import pfba_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_RSET = 4'd3;
  localparam logic [3:0] S_RRD  = 4'd4;
  localparam logic [3:0] S_RWR  = 4'd5;
  localparam logic [3:0] S_RFIN = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SCHK = 4'd8;
  localparam logic [3:0] S_SBIT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [WADDR_W-1:0] clr_q, clr_d;
  pfba_cmd_t          cmd_q, cmd_d;
  logic [PFN_W-1:0]   rs_start_q, rs_start_d;
  logic [PFN_W-1:0]   rs_n_q, rs_n_d;
  logic               rs_val_q, rs_val_d;
  logic               force_q, force_d;
  logic [WADDR_W-1:0] wcur_q, wcur_d;
  logic [WADDR_W-1:0] wlast_q, wlast_d;
  logic [BIT_W-1:0]   lob_q, lob_d;
  logic [BIT_W-1:0]   hib_q, hib_d;
  logic [CNT_W-1:0]   run_q, run_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [MW-1:0]      word_q, word_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [1:0]         status_q, status_d;
  logic [ADDR_W-1:0]  paddr_q, paddr_d;

  logic [PFN_W-1:0]   first;
  logic [PFN_W-1:0]   blocks;
  logic [SUM_W-1:0]   room;
  logic [FRAME_W-1:0] last;
  logic [BIT_W-1:0]   hi_sel;
  logic [MW-1:0]      mask;
  logic [CNT_W:0]     run32;
  logic [CNT_W-1:0]   run1;
  logic [CNT_W-1:0]   fpos;
  logic [FRAME_W-1:0] found_start;
  logic [CNT_W-1:0]   free_now;

  assign first    = cmd_q.address[ADDR_W-1:PAGE_SHIFT];
  assign blocks   = cmd_q.byte_length[ADDR_W-1:PAGE_SHIFT];
  assign room     = SUM_W'(FRAMES) - SUM_W'(rs_start_q);
  assign last     = (room < SUM_W'(rs_n_q)) ? FRAME_W'(FRAMES - 1)
                                            : FRAME_W'(rs_start_q + rs_n_q - 1'b1);
  assign hi_sel   = (wcur_q == wlast_q) ? hib_q : BIT_W'(MW - 1);
  assign mask     = ({MW{1'b1}} << lob_q) & ({MW{1'b1}} >> (BIT_W'(MW - 1) - hi_sel));
  assign run32    = (CNT_W + 1)'(run_q) + (CNT_W + 1)'(MW);
  assign run1     = run_q + 1'b1;
  assign fpos     = CNT_W'({wcur_q, bit_q}) + 1'b1 - cmd_q.page_count;
  assign free_now = sat_sub(total_q, PFN_W'(used_q));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    rs_start_d = rs_start_q;
    rs_n_d     = rs_n_q;
    rs_val_d   = rs_val_q;
    force_d    = force_q;
    wcur_d     = wcur_q;
    wlast_d    = wlast_q;
    lob_d      = lob_q;
    hib_d      = hib_q;
    run_d      = run_q;
    bit_d      = bit_q;
    word_d     = word_q;
    total_d    = total_q;
    used_d     = used_q;
    status_d   = status_q;
    paddr_d    = paddr_q;
    found_start = '0;
    we_o       = 1'b0;
    waddr_o    = wcur_q;
    wdata_o    = '0;
    re_o       = 1'b0;
    raddr_o    = wcur_q;

    case (state_q)
      S_CLR: begin
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = '1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == WADDR_W'(WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d    = cmd_i;
          status_d = ST_OK;
          paddr_d  = '0;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_q.command)
          CMD_ENABLE, CMD_DISABLE: begin
            rs_start_d = first;
            rs_n_d     = blocks;
            rs_val_d   = (cmd_q.command == CMD_DISABLE);
            force_d    = 1'b1;
            total_d    = (cmd_q.command == CMD_ENABLE) ? sat_add(total_q, blocks)
                                                       : sat_sub(total_q, blocks);
            state_d    = S_RSET;
          end
          CMD_ALLOC: begin
            if (cmd_q.page_count == '0) begin
              status_d = ST_ZERO;
              state_d  = S_DONE;
            end else if (free_now < cmd_q.page_count) begin
              status_d = ST_NOROOM;
              state_d  = S_DONE;
            end else begin
              wcur_d  = '0;
              run_d   = '0;
              state_d = S_SRD;
            end
          end
          default: begin
            if (cmd_q.page_count == '0) begin
              state_d = S_DONE;
            end else begin
              rs_start_d = first;
              rs_n_d     = PFN_W'(cmd_q.page_count);
              rs_val_d   = 1'b0;
              force_d    = 1'b0;
              used_d     = sat_sub(used_q, PFN_W'(cmd_q.page_count));
              state_d    = S_RSET;
            end
          end
        endcase
      end
      S_RSET: begin
        if (rs_start_q >= PFN_W'(FRAMES) || rs_n_q == '0) begin
          state_d = S_RFIN;
        end else begin
          wcur_d  = rs_start_q[FRAME_W-1:BIT_W];
          lob_d   = rs_start_q[BIT_W-1:0];
          wlast_d = last[FRAME_W-1:BIT_W];
          hib_d   = last[BIT_W-1:0];
          state_d = S_RRD;
        end
      end
      S_RRD: begin
        re_o    = 1'b1;
        state_d = S_RWR;
      end
      S_RWR: begin
        we_o    = 1'b1;
        wdata_o = rs_val_q ? (rdata_i | mask) : (rdata_i & ~mask);
        lob_d   = '0;
        if (wcur_q == wlast_q) begin
          state_d = S_RFIN;
        end else begin
          wcur_d  = wcur_q + 1'b1;
          state_d = S_RRD;
        end
      end
      S_RFIN: begin
        if (force_q) begin
          force_d    = 1'b0;
          rs_start_d = '0;
          rs_n_d     = PFN_W'(1);
          rs_val_d   = 1'b1;
          state_d    = S_RSET;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SRD: begin
        re_o    = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        word_d = rdata_i;
        bit_d  = '0;
        if (rdata_i == '0) begin
          if (run32 >= (CNT_W + 1)'(cmd_q.page_count)) begin
            found_start = FRAME_W'(CNT_W'({wcur_q, {BIT_W{1'b0}}}) - run_q);
            rs_start_d  = PFN_W'(found_start);
            rs_n_d      = PFN_W'(cmd_q.page_count);
            rs_val_d    = 1'b1;
            force_d     = 1'b0;
            used_d      = sat_add(used_q, PFN_W'(cmd_q.page_count));
            paddr_d     = ADDR_W'({found_start, {PAGE_SHIFT{1'b0}}});
            state_d     = S_RSET;
          end else begin
            run_d = run32[CNT_W-1:0];
            if (wcur_q == WADDR_W'(WORDS - 1)) begin
              status_d = ST_NOROOM;
              state_d  = S_DONE;
            end else begin
              wcur_d  = wcur_q + 1'b1;
              state_d = S_SRD;
            end
          end
        end else if (rdata_i == '1) begin
          run_d = '0;
          if (wcur_q == WADDR_W'(WORDS - 1)) begin
            status_d = ST_NOROOM;
            state_d  = S_DONE;
          end else begin
            wcur_d  = wcur_q + 1'b1;
            state_d = S_SRD;
          end
        end else begin
          state_d = S_SBIT;
        end
      end
      S_SBIT: begin
        if (!word_q[bit_q] && run1 == cmd_q.page_count) begin
          found_start = fpos[FRAME_W-1:0];
          rs_start_d  = PFN_W'(found_start);
          rs_n_d      = PFN_W'(cmd_q.page_count);
          rs_val_d    = 1'b1;
          force_d     = 1'b0;
          used_d      = sat_add(used_q, PFN_W'(cmd_q.page_count));
          paddr_d     = ADDR_W'({found_start, {PAGE_SHIFT{1'b0}}});
          state_d     = S_RSET;
        end else begin
          run_d = word_q[bit_q] ? '0 : run1;
          bit_d = bit_q + 1'b1;
          if (bit_q == BIT_W'(MW - 1)) begin
            if (wcur_q == WADDR_W'(WORDS - 1)) begin
              status_d = ST_NOROOM;
              state_d  = S_DONE;
            end else begin
              wcur_d  = wcur_q + 1'b1;
              state_d = S_SRD;
            end
          end
        end
      end
      S_DONE: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      total_q  <= '0;
      used_q   <= '0;
      force_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      total_q  <= total_d;
      used_q   <= used_d;
      force_q  <= force_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rs_start_q <= rs_start_d;
    rs_n_q     <= rs_n_d;
    rs_val_q   <= rs_val_d;
    wcur_q     <= wcur_d;
    wlast_q    <= wlast_d;
    lob_q      <= lob_d;
    hib_q      <= hib_d;
    run_q      <= run_d;
    bit_q      <= bit_d;
    word_q     <= word_d;
    status_q   <= status_d;
    paddr_q    <= paddr_d;
  end

  assign stat_o.idle     = (state_q == S_IDLE);
  assign stat_o.done     = (state_q == S_DONE) && slot_free_i;
  assign stat_o.clearing = (state_q == S_CLR);

  assign rsp_o.status       = status_q;
  assign rsp_o.page_address = paddr_q;
  assign rsp_o.free_pages   = free_now;

endmodule

`default_nettype wire

// ===== hdl/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator - first-fit page frame allocator
// Bitmap of 65536 frames, region enable/disable, allocate and free.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  cmd_i   | in  | command, address, byte_length, page_count
//  rsp_o   | out | status, page_address, free_pages
//
//  After reset a clearing pass writes all 2048 bitmap words as used.
//  Free rewrites each touched bitmap word; enable/disable set frame 0 used.
//  Allocate reads each scanned word, walks a partly used word bit by bit,
//  then reads and rewrites each word of the run that it marks.
//  One word at a time; the result register frees the input once the word is
//  loaded, and a full result register holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_bitmap_allocator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfba_cmd_if.sink  cmd_i,
  pfba_rsp_if.source rsp_o
);
  import pfba_pkg::*;

  pfba_cmd_t          cmd;
  pfba_rsp_t          rsp;
  pfba_stat_t         stat;
  logic               slot_free;
  logic               rsp_valid_q;
  pfba_rsp_t          rsp_q;
  logic               we;
  logic [WADDR_W-1:0] waddr;
  logic [MW-1:0]      wdata;
  logic               re;
  logic [WADDR_W-1:0] raddr;
  logic [MW-1:0]      rdata;

  assign cmd.command     = cmd_i.command;
  assign cmd.address     = cmd_i.address;
  assign cmd.byte_length = cmd_i.byte_length;
  assign cmd.page_count  = cmd_i.page_count;

  assign cmd_i.ready = stat.idle;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;

  pfba_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.valid && cmd_i.ready),
    .cmd_i       (cmd),
    .slot_free_i (slot_free),
    .stat_o      (stat),
    .rsp_o       (rsp),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  pfba_map_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (stat.done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      rsp_q <= rsp;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.page_address = rsp_q.page_address;
  assign rsp_o.free_pages   = rsp_q.free_pages;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("accepted a word while busy");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !cmd_i.ready)
    else $error("ready during clearing pass");

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |-> rsp_o.page_address == '0)
    else $error("address on failed result");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.free_pages <= CNT_W'(FRAMES) && rsp_o.status != 2'd3)
    else $error("bad result word");

endmodule

`default_nettype wire

// ===== tb/sv/pfba_checker.sv =====
// ----------------------------------------------------------------------------
// pfba_checker - page frame allocator response checker
// Watches command and response words, keeps its own bitmap and page counters,
// predicts each response and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pfba_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pfba_cmd_if  cmd_mon_i,
  pfba_rsp_if  rsp_mon_i,
  output int   errors_o,
  output int   pending_o
);
  import pfba_pkg::*;

  bit          frame_used [FRAMES];
  int unsigned total_pg;
  int unsigned used_pg;
  int unsigned free_top;  // no free frame at or above this index
  pfba_rsp_t   expected_rsp_q[$];

  function automatic int unsigned sat_plus(int unsigned a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > FRAMES) ? FRAMES : int'(s);
  endfunction

  function automatic int unsigned sat_minus(int unsigned a, longint unsigned b);
    return (longint'(a) > b) ? int'(longint'(a) - b) : 0;
  endfunction

  function automatic void mark_frames(longint unsigned start, longint unsigned n, bit used);
    longint unsigned stop;
    if (start >= FRAMES) return;
    stop = (start + n > FRAMES) ? FRAMES : start + n;
    for (longint unsigned f = start; f < stop; f++) frame_used[f] = used;
    if (!used && stop > free_top) free_top = int'(stop);
    if (used && start < free_top && stop >= free_top) free_top = int'(start);
  endfunction

  function automatic pfba_rsp_t predict_response(pfba_cmd_t c);
    pfba_rsp_t       r;
    longint unsigned first;
    longint unsigned pages;
    int unsigned     run;
    int unsigned     hit;
    bit              found;
    first = c.address >> PAGE_SHIFT;
    pages = c.byte_length >> PAGE_SHIFT;
    r = '0;
    r.status = ST_OK;
    case (c.command)
      CMD_ENABLE, CMD_DISABLE: begin
        mark_frames(first, pages, c.command == CMD_DISABLE);
        if (c.command == CMD_ENABLE) total_pg = sat_plus(total_pg, pages);
        else total_pg = sat_minus(total_pg, pages);
        frame_used[0] = 1'b1;
      end
      CMD_ALLOC: begin
        if (c.page_count == 0) begin
          r.status = ST_ZERO;
        end else if (sat_minus(total_pg, used_pg) < c.page_count) begin
          r.status = ST_NOROOM;
        end else begin
          run = 0;
          found = 1'b0;
          hit = 0;
          for (int unsigned f = 0; f < free_top && !found; f++) begin
            run = frame_used[f] ? 0 : run + 1;
            if (run == c.page_count) begin
              found = 1'b1;
              hit = f + 1 - c.page_count;
            end
          end
          if (!found) begin
            r.status = ST_NOROOM;
          end else begin
            mark_frames(hit, c.page_count, 1'b1);
            used_pg = sat_plus(used_pg, c.page_count);
            r.page_address = ADDR_W'(longint'(hit) << PAGE_SHIFT);
          end
        end
      end
      default: begin
        if (c.page_count != 0) begin
          mark_frames(first, c.page_count, 1'b0);
          used_pg = sat_minus(used_pg, c.page_count);
        end
      end
    endcase
    r.free_pages = CNT_W'(sat_minus(total_pg, used_pg));
    return r;
  endfunction

  function automatic void report_mismatch(string what, longint unsigned got,
                                          longint unsigned want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pfba_cmd_t c;
    pfba_rsp_t want;
    if (!rst_ni) begin
      foreach (frame_used[f]) frame_used[f] = 1'b1;
      total_pg = 0;
      used_pg = 0;
      free_top = 0;
      expected_rsp_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        c.command = cmd_mon_i.command;
        c.address = cmd_mon_i.address;
        c.byte_length = cmd_mon_i.byte_length;
        c.page_count = cmd_mon_i.page_count;
        expected_rsp_q.push_back(predict_response(c));
      end
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected word", rsp_mon_i.status, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_mon_i.status !== want.status)
            report_mismatch("status", rsp_mon_i.status, want.status);
          if (rsp_mon_i.page_address !== want.page_address)
            report_mismatch("page_address", rsp_mon_i.page_address, want.page_address);
          if (rsp_mon_i.free_pages !== want.free_pages)
            report_mismatch("free_pages", rsp_mon_i.free_pages, want.free_pages);
        end
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_page_frame_bitmap_allocator - allocator testbench top
// Directed corner commands, then random traffic on a small frame pool with
// random idle gaps on both channels and one long response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned     RANDOM_WORDS = 1900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   rsp_seen;
  longint unsigned cycles;

  pfba_cmd_if cmd_ch ();
  pfba_rsp_if rsp_ch ();

  page_frame_bitmap_allocator i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  pfba_checker i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_mon_i(cmd_ch),
    .rsp_mon_i(rsp_ch),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_ENABLE;
    cmd_ch.address = '0;
    cmd_ch.byte_length = '0;
    cmd_ch.page_count = '0;
    rsp_ch.ready = 1'b0;
  end

  // response side: random gaps, one long hold-off
  initial begin
    int gap;
    rsp_seen = 0;
    @(posedge rst_ni);
    forever begin
      gap = (rsp_seen == 40) ? 600 : $urandom_range(0, 3);
      if (rsp_seen > 200 && rsp_seen < 260) gap = 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      rsp_seen++;
    end
  end

  task automatic send_word(logic [1:0] c, logic [31:0] a, logic [31:0] l,
                           logic [CNT_W-1:0] n, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.address <= a;
    cmd_ch.byte_length <= l;
    cmd_ch.page_count <= n;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pool_addr();
    return {20'(($urandom_range(1, 1023))), 12'($urandom_range(0, 4095))};
  endfunction

  initial begin
    int          pick;
    bit          burst;
    logic [31:0] a;
    logic [31:0] l;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd0,     0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd1,     0);
    send_word(CMD_FREE,    32'h0000_5000, 32'h0,       17'd0,     0);
    send_word(CMD_ENABLE,  32'h0,        32'hffff_ffff, 17'd0,    0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd65536, 0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd65535, 0);
    send_word(CMD_FREE,    32'h0000_1000, 32'h0,       17'd65535, 0);
    send_word(CMD_DISABLE, 32'h0,        32'hffff_ffff, 17'd0,    0);
    send_word(CMD_ENABLE,  32'h0000_1000, 32'h0040_0fff, 17'd0,   0);
    send_word(CMD_FREE,    32'h0000_0fff, 32'h0,       17'd1,     0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd1,     0);
    send_word(CMD_DISABLE, 32'hffff_f000, 32'h0000_5000, 17'd0,   0);
    send_word(CMD_ENABLE,  32'hffff_ffff, 32'h0000_3000, 17'd0,   0);
    send_word(CMD_FREE,    32'hffff_ffff, 32'h0,       17'd65536, 0);
    send_word(CMD_ENABLE,  32'h0fff_f000, 32'h0000_2000, 17'd0,   0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd1024,  0);
    send_word(CMD_DISABLE, 32'h0fff_f000, 32'h0000_2000, 17'd0,   0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd3,     0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd5,     0);
    send_word(CMD_DISABLE, 32'h0000_5000, 32'h0000_1fff, 17'd0,   0);
    send_word(CMD_ALLOC,   32'h0,        32'h0,        17'd10,    0);
    send_word(CMD_DISABLE, 32'h0,        32'hffff_ffff, 17'd0,    0);
    send_word(CMD_ENABLE,  32'h0000_1000, 32'h003f_f000, 17'd0,   0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      burst = (i >= 300 && i < 360);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(CMD_ALLOC, $urandom, $urandom,
                  ($urandom_range(0, 49) == 0) ? 17'($urandom_range(0, 65536))
                                               : 17'($urandom_range(1, 16)), burst);
      end else if (pick < 75) begin
        send_word(CMD_FREE, pool_addr(), $urandom, 17'($urandom_range(0, 16)), burst);
      end else if (pick < 85) begin
        send_word(CMD_ENABLE, pool_addr(), $urandom_range(0, 32'h0002_0fff), 17'($urandom),
                  burst);
      end else if (pick < 95) begin
        send_word(CMD_DISABLE, pool_addr(), $urandom_range(0, 32'h0001_0fff), 17'($urandom),
                  burst);
      end else begin
        a = $urandom | 32'h1000_0000;
        l = $urandom;
        send_word(2'($urandom_range(0, 3)), a, l, 17'($urandom_range(0, 65536)), burst);
      end
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
